[rtl/fibre_link_startup_regs_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fibre link start-up register block
// Implication forms shared by the block's checker.
// ----------------------------------------------------------------------------
`ifndef FIBRE_LINK_STARTUP_REGS_MACROS_SVH
`define FIBRE_LINK_STARTUP_REGS_MACROS_SVH

// same-cycle implication, reset masked
`define FLSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define FLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/flsr_pkg.sv]
// ----------------------------------------------------------------------------
// flsr_pkg
// Widths, codes, reset values and shared types of the link start-up block.
// ----------------------------------------------------------------------------
package flsr_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned SEL_W        = 3;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned TOP_RATE_BIT = 6;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [SEL_W-1:0] SEL_CONTROL = 3'd0;
  localparam logic [SEL_W-1:0] SEL_PREF    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_CURRENT = 3'd2;
  localparam logic [SEL_W-1:0] SEL_STATUS  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_REMOTE  = 3'd4;

  localparam logic [PHASE_W-1:0] PH_RESET   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SYNC    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_VERSION = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PARAMS  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PASSIVE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_OPER    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ALLOWED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TICKS   = 2'd3;

  localparam int unsigned CTL_RESET_IDX = 0;
  localparam int unsigned CTL_TYPE_IDX  = 1;

  localparam logic [DATA_W-1:0] CTL_RESET_VAL    = 16'h0003;
  localparam logic [DATA_W-1:0] CTL_TYPE_MASK    = 16'h0002;
  localparam logic [DATA_W-1:0] PREF_RATE_RST    = 16'h007f;
  localparam logic [DATA_W-1:0] REMOTE_RATE_RST  = 16'hffff;
  localparam logic [DATA_W-1:0] STEP_TICKS_RST   = 16'd200;
  localparam logic [DATA_W-1:0] SYNC_TICKS_RST   = 16'd1000;
  localparam logic [DATA_W-1:0] REMOTE_ALARMS    = 16'h0007;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SEL_W-1:0]  reg_select;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] byte_mask;
    logic              fibre_present;
    logic              module_present;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [PHASE_W-1:0] link_state;
    logic [DATA_W-1:0]  current_rate;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

endpackage

[rtl/flsr_item_if.sv]
// ----------------------------------------------------------------------------
// flsr_item_if
// Input item channel: valid/ready with one register access or tick.
// ----------------------------------------------------------------------------
interface flsr_item_if import flsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] byte_mask;
  logic              fibre_present;
  logic              module_present;

  modport source (output valid, command, reg_select, write_data, byte_mask,
                  fibre_present, module_present, input ready);
  modport sink (input valid, command, reg_select, write_data, byte_mask,
                fibre_present, module_present, output ready);
endinterface

[rtl/flsr_result_if.sv]
// ----------------------------------------------------------------------------
// flsr_result_if
// Result channel: valid/ready with read data, link state and chosen rate.
// ----------------------------------------------------------------------------
interface flsr_result_if import flsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [PHASE_W-1:0] link_state;
  logic [DATA_W-1:0]  current_rate;

  modport source (output valid, read_data, link_state, current_rate, input ready);
  modport sink (input valid, read_data, link_state, current_rate, output ready);
endinterface

[rtl/flsr_cfg_if.sv]
// ----------------------------------------------------------------------------
// flsr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface flsr_cfg_if import flsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/flsr_rate_pick.sv]
// ----------------------------------------------------------------------------
// flsr_rate_pick
// Priority encoder: highest common rate bit at or below RATE_TOP, one-hot.
// ----------------------------------------------------------------------------
module flsr_rate_pick import flsr_pkg::*; #(
  parameter int unsigned RATE_TOP = TOP_RATE_BIT
) (
  input  logic [DATA_W-1:0] common,
  output logic [DATA_W-1:0] pick
);

  always_comb begin
    pick = '0;
    for (int i = 0; i <= int'(RATE_TOP); i++) begin
      if (common[i]) begin
        pick = DATA_W'(1) << i;
      end
    end
  end

endmodule

[rtl/flsr_link_core.sv]
// ----------------------------------------------------------------------------
// flsr_link_core
// Register file, configuration and link state machine; one item per step.
// ----------------------------------------------------------------------------
module flsr_link_core import flsr_pkg::*; #(
  parameter int unsigned RATE_TOP = TOP_RATE_BIT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_wr_t cfg,
  output result_t res
);

  logic [DATA_W-1:0]  remote_rate_r;
  logic               sync_allowed_r;
  logic [DATA_W-1:0]  step_ticks_r;
  logic [DATA_W-1:0]  sync_ticks_r;

  logic [DATA_W-1:0]  control_r, control_nxt;
  logic [DATA_W-1:0]  pref_r, pref_nxt;
  logic [DATA_W-1:0]  chosen_r, chosen_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [DATA_W-1:0]  dwell_r, dwell_nxt;

  logic [DATA_W-1:0]  pick;
  logic [DATA_W-1:0]  cnt_inc;
  logic               sync_done;
  logic               step_done;
  logic [DATA_W-1:0]  status_val;
  logic [DATA_W-1:0]  remote_val;
  logic [DATA_W-1:0]  ctl_mask;
  logic [DATA_W-1:0]  rd;
  logic [PHASE_W-1:0] eff_phase;

  flsr_rate_pick #(
    .RATE_TOP (RATE_TOP)
  ) u_pick (
    .common (pref_r & remote_rate_r),
    .pick   (pick)
  );

  assign cnt_inc    = dwell_r + DATA_W'(1);
  assign sync_done  = (cnt_inc >= sync_ticks_r);
  assign step_done  = (cnt_inc >= step_ticks_r);
  assign status_val = {5'b0, (phase_r != PH_OPER) ? 5'h1f : 5'h00, 3'b111, phase_r};
  assign remote_val = (phase_r == PH_OPER) ? '0 : REMOTE_ALARMS;
  assign ctl_mask   = item.byte_mask & ~CTL_TYPE_MASK;
  assign eff_phase  = (phase_r > PH_OPER) ? PH_RESET : phase_r;

  always_comb begin
    control_nxt = control_r;
    pref_nxt    = pref_r;
    chosen_nxt  = chosen_r;
    phase_nxt   = phase_r;
    dwell_nxt   = dwell_r;
    rd          = '0;
    case (item.command)
      CMD_READ: begin
        case (item.reg_select)
          SEL_CONTROL: rd = control_r;
          SEL_PREF:    rd = pref_r;
          SEL_CURRENT: rd = chosen_r;
          SEL_STATUS:  rd = status_val;
          SEL_REMOTE:  rd = remote_val;
          default:     rd = '0;
        endcase
        rd = rd & item.byte_mask;
      end
      CMD_WRITE: begin
        case (item.reg_select)
          SEL_CONTROL: begin
            control_nxt = (control_r & ~ctl_mask) | (item.write_data & ctl_mask);
            rd          = control_nxt & item.byte_mask;
          end
          SEL_PREF: begin
            pref_nxt = (pref_r & ~item.byte_mask) | (item.write_data & item.byte_mask);
            rd       = pref_nxt & item.byte_mask;
          end
          default: rd = item.write_data & item.byte_mask;
        endcase
      end
      CMD_TICK: begin
        if (control_r[CTL_RESET_IDX]) begin
          phase_nxt  = PH_RESET;
          pref_nxt   = PREF_RATE_RST;
          chosen_nxt = '0;
          dwell_nxt  = '0;
        end else if (pref_r == '0) begin
          phase_nxt  = PH_SYNC;
          chosen_nxt = '0;
          dwell_nxt  = '0;
        end else if (!item.fibre_present || !item.module_present) begin
          phase_nxt = PH_SYNC;
          dwell_nxt = '0;
        end else begin
          phase_nxt = eff_phase;
          case (eff_phase)
            PH_SYNC: begin
              if (sync_done) begin
                dwell_nxt = '0;
                if (sync_allowed_r) begin
                  chosen_nxt = pick;
                  if (pick != '0) begin
                    phase_nxt = PH_VERSION;
                  end
                end
              end else begin
                dwell_nxt = cnt_inc;
              end
            end
            PH_OPER: dwell_nxt = '0;
            default: begin
              if (step_done) begin
                dwell_nxt = '0;
                phase_nxt = eff_phase + PHASE_W'(1);
              end else begin
                dwell_nxt = cnt_inc;
              end
            end
          endcase
        end
      end
      default: rd = '0;
    endcase
  end

  assign res.read_data    = rd;
  assign res.link_state   = phase_nxt;
  assign res.current_rate = chosen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_rate_r  <= REMOTE_RATE_RST;
      sync_allowed_r <= 1'b1;
      step_ticks_r   <= STEP_TICKS_RST;
      sync_ticks_r   <= SYNC_TICKS_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_REMOTE_RATE:  remote_rate_r  <= cfg.data;
        CFG_SYNC_ALLOWED: sync_allowed_r <= cfg.data[0];
        CFG_STEP_TICKS:   step_ticks_r   <= cfg.data;
        CFG_SYNC_TICKS:   sync_ticks_r   <= cfg.data;
        default:          remote_rate_r  <= remote_rate_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= CTL_RESET_VAL;
      pref_r    <= PREF_RATE_RST;
      chosen_r  <= '0;
      phase_r   <= PH_RESET;
      dwell_r   <= '0;
    end else if (step) begin
      control_r <= control_nxt;
      pref_r    <= pref_nxt;
      chosen_r  <= chosen_nxt;
      phase_r   <= phase_nxt;
      dwell_r   <= dwell_nxt;
    end
  end

endmodule

[rtl/fibre_link_startup_regs.sv]
// ----------------------------------------------------------------------------
// fibre_link_startup_regs
// Link start-up register block: masked register access and tick-driven
// link state machine behind an input register and a result register.
//
//   channel   role    transfer carries
//   in_ch     sink    command, reg_select, write_data, byte_mask, presence
//   out_ch    source  read_data, link_state, current_rate
//   cfg_ch    sink    index, data (always ready)
//
// One item per cycle sustained while out_ch is ready; each item passes through
// the input register, then the result register, before its result leaves.
// Synchronous active-low reset restores the core registers and link state.
// A stall on out_ch freezes the state machine; one more item is still taken
// into the input register while a result waits.
// ----------------------------------------------------------------------------
module fibre_link_startup_regs import flsr_pkg::*; #(
  parameter int unsigned RATE_TOP = TOP_RATE_BIT
) (
  input logic         clk,
  input logic         rst_n,
  flsr_item_if.sink   in_ch,
  flsr_result_if.source out_ch,
  flsr_cfg_if.sink    cfg_ch
);

  logic    stage_valid_r, stage_valid_nxt;
  item_t   stage_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  result_t core_res;
  cfg_wr_t cfg_wr;
  logic    advance;
  logic    step;
  logic    in_fire;

  assign advance  = !out_valid_r || out_ch.ready;
  assign step     = stage_valid_r && advance;
  assign in_ch.ready = !stage_valid_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.index = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  flsr_link_core #(
    .RATE_TOP (RATE_TOP)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (stage_r),
    .cfg   (cfg_wr),
    .res   (core_res)
  );

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? stage_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r.command        <= in_ch.command;
      stage_r.reg_select     <= in_ch.reg_select;
      stage_r.write_data     <= in_ch.write_data;
      stage_r.byte_mask      <= in_ch.byte_mask;
      stage_r.fibre_present  <= in_ch.fibre_present;
      stage_r.module_present <= in_ch.module_present;
    end
    if (step) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_r.read_data;
  assign out_ch.link_state   = out_r.link_state;
  assign out_ch.current_rate = out_r.current_rate;

endmodule

[rtl/flsr_checker.sv]
// ----------------------------------------------------------------------------
// flsr_checker
// Port-level checks on the result channel of the link start-up block.
// ----------------------------------------------------------------------------
`include "fibre_link_startup_regs_macros.svh"

module flsr_checker import flsr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  read_data,
  input logic [PHASE_W-1:0] link_state,
  input logic [DATA_W-1:0]  current_rate
);

  `FLSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(read_data) && $stable(link_state) && $stable(current_rate),
    "stalled result changed")

  `FLSR_ASSERT_IMPL(a_state_range, clk, rst_n, out_valid, link_state <= PH_OPER,
    "link state out of range")

  `FLSR_ASSERT_IMPL(a_rate_onehot, clk, rst_n, out_valid, $onehot0(current_rate),
    "current rate not one-hot")

  `FLSR_ASSERT_IMPL(a_reset_no_rate, clk, rst_n, out_valid && (link_state == PH_RESET),
    current_rate == '0, "rate set in reset state")

endmodule

bind fibre_link_startup_regs flsr_checker u_flsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_data    (out_ch.read_data),
  .link_state   (out_ch.link_state),
  .current_rate (out_ch.current_rate)
);

[verif/fibre_link_startup_regs_tb.sv]
// ----------------------------------------------------------------------------
// fibre_link_startup_regs_tb
// Self-checking bench for the link start-up register block. A short table
// covers reset values, masking, forcing rules and the walk through the link
// states; randomized phases with varying dwell and rate settings follow.
// Every result is checked field by field against the table's value if given,
// else against an in-bench model of the register file and the tick-driven
// state machine. Both channels idle at random outside the gapless phases.
// ----------------------------------------------------------------------------
module fibre_link_startup_regs_tb;
  import flsr_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned PHASES        = 13;
  localparam int unsigned PHASE_ITEMS   = 150;

  localparam logic [CMD_W-1:0]  CMD_SPARE     = 2'd3;
  localparam logic [SEL_W-1:0]  SEL_SPARE     = 3'd7;
  localparam logic [DATA_W-1:0] STATUS_LOCKS  = 16'h0038;
  localparam logic [DATA_W-1:0] STATUS_ALARMS = 16'h07c0;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    val;
    item_t                it;
    bit                   has_want;
    result_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  flsr_item_if   in_ch();
  flsr_result_if out_ch();
  flsr_cfg_if    cfg_ch();

  fibre_link_startup_regs i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  logic [DATA_W-1:0]  mdl_ctl;
  logic [DATA_W-1:0]  mdl_pref;
  logic [DATA_W-1:0]  mdl_rate;
  logic [DATA_W-1:0]  mdl_dwell;
  logic [PHASE_W-1:0] mdl_phase;
  logic [DATA_W-1:0]  mdl_remote;
  logic               mdl_allow;
  logic [DATA_W-1:0]  mdl_step;
  logic [DATA_W-1:0]  mdl_sync;

  result_t   pending_results[$];
  stim_row_t script[$];
  bit        cur_has_want;
  result_t   cur_want;
  bit        gapless;
  int        mismatch_cnt;

  function automatic void link_reset();
    mdl_remote = REMOTE_RATE_RST;
    mdl_allow  = 1'b1;
    mdl_step   = STEP_TICKS_RST;
    mdl_sync   = SYNC_TICKS_RST;
    mdl_ctl    = CTL_RESET_VAL;
    mdl_pref   = PREF_RATE_RST;
    mdl_rate   = '0;
    mdl_phase  = PH_RESET;
    mdl_dwell  = '0;
  endfunction

  function automatic void link_config(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      CFG_REMOTE_RATE:  mdl_remote = val;
      CFG_SYNC_ALLOWED: mdl_allow  = val[0];
      CFG_STEP_TICKS:   mdl_step   = val;
      CFG_SYNC_TICKS:   mdl_sync   = val;
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] status_word();
    logic [DATA_W-1:0] v;
    v = {{(DATA_W-PHASE_W){1'b0}}, mdl_phase} | STATUS_LOCKS;
    if (mdl_phase != PH_OPER) v = v | STATUS_ALARMS;
    return v;
  endfunction

  function automatic logic dwell_expired(logic [DATA_W-1:0] lim);
    mdl_dwell = mdl_dwell + 16'd1;
    if (mdl_dwell >= lim) begin
      mdl_dwell = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void choose_rate();
    logic [DATA_W-1:0] common;
    logic              found;
    common   = mdl_pref & mdl_remote;
    found    = 1'b0;
    mdl_rate = '0;
    for (int b = int'(TOP_RATE_BIT); b >= 0; b--) begin
      if (!found && common[b]) begin
        mdl_rate[b] = 1'b1;
        found       = 1'b1;
      end
    end
    if (found) mdl_phase = PH_VERSION;
  endfunction

  function automatic void link_tick(logic fibre, logic sfp);
    logic done;
    if (mdl_ctl[CTL_RESET_IDX]) begin
      mdl_phase = PH_RESET;
      mdl_pref  = PREF_RATE_RST;
      mdl_rate  = '0;
      mdl_dwell = '0;
    end else if (mdl_pref == '0) begin
      mdl_phase = PH_SYNC;
      mdl_rate  = '0;
      mdl_dwell = '0;
    end else if (!fibre || !sfp) begin
      mdl_phase = PH_SYNC;
      mdl_dwell = '0;
    end else begin
      if (mdl_phase > PH_OPER) mdl_phase = PH_RESET;
      case (mdl_phase)
        PH_SYNC: begin
          done = dwell_expired(mdl_sync);
          if (done && mdl_allow) choose_rate();
        end
        PH_OPER: mdl_dwell = '0;
        default: begin
          if (dwell_expired(mdl_step)) mdl_phase = mdl_phase + 3'd1;
        end
      endcase
    end
  endfunction

  function automatic result_t link_step(item_t it);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] m;
    result_t           r;
    rd = '0;
    case (it.command)
      CMD_READ: begin
        case (it.reg_select)
          SEL_CONTROL: rd = mdl_ctl;
          SEL_PREF:    rd = mdl_pref;
          SEL_CURRENT: rd = mdl_rate;
          SEL_STATUS:  rd = status_word();
          SEL_REMOTE:  rd = (mdl_phase == PH_OPER) ? '0 : REMOTE_ALARMS;
          default:     rd = '0;
        endcase
        rd = rd & it.byte_mask;
      end
      CMD_WRITE: begin
        if (it.reg_select == SEL_CONTROL) begin
          m       = it.byte_mask & ~CTL_TYPE_MASK;
          mdl_ctl = (mdl_ctl & ~m) | (it.write_data & m);
          rd      = mdl_ctl & it.byte_mask;
        end else if (it.reg_select == SEL_PREF) begin
          mdl_pref = (mdl_pref & ~it.byte_mask) | (it.write_data & it.byte_mask);
          rd       = mdl_pref & it.byte_mask;
        end else begin
          rd = it.write_data & it.byte_mask;
        end
      end
      CMD_TICK: link_tick(it.fibre_present, it.module_present);
      default: ;
    endcase
    r.read_data    = rd;
    r.link_state   = mdl_phase;
    r.current_rate = mdl_rate;
    return r;
  endfunction

  function automatic item_t make_item(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                                      logic [DATA_W-1:0] data, logic [DATA_W-1:0] mask,
                                      logic fibre, logic sfp);
    item_t it;
    it.command        = cmd;
    it.reg_select     = sel;
    it.write_data     = data;
    it.byte_mask      = mask;
    it.fibre_present  = fibre;
    it.module_present = sfp;
    return it;
  endfunction

  function automatic void plain_row(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                                    logic [DATA_W-1:0] data, logic [DATA_W-1:0] mask,
                                    logic fibre, logic sfp);
    stim_row_t row;
    row.is_cfg   = 1'b0;
    row.idx      = '0;
    row.val      = '0;
    row.it       = make_item(cmd, sel, data, mask, fibre, sfp);
    row.has_want = 1'b0;
    row.want     = '0;
    script.push_back(row);
  endfunction

  function automatic void known_row(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                                    logic [DATA_W-1:0] data, logic [DATA_W-1:0] mask,
                                    logic [DATA_W-1:0] rd, logic [PHASE_W-1:0] st,
                                    logic [DATA_W-1:0] rate);
    stim_row_t row;
    row.is_cfg              = 1'b0;
    row.idx                 = '0;
    row.val                 = '0;
    row.it                  = make_item(cmd, sel, data, mask, 1'b1, 1'b1);
    row.has_want            = 1'b1;
    row.want.read_data      = rd;
    row.want.link_state     = st;
    row.want.current_rate   = rate;
    script.push_back(row);
  endfunction

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    stim_row_t row;
    row.is_cfg   = 1'b1;
    row.idx      = idx;
    row.val      = val;
    row.it       = '0;
    row.has_want = 1'b0;
    row.want     = '0;
    script.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    it.write_data     = 16'($urandom_range(0, 16'hffff));
    it.byte_mask      = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'($urandom_range(0, 16'hffff));
    it.fibre_present  = ($urandom_range(0, 19) != 0);
    it.module_present = ($urandom_range(0, 19) != 0);
    it.reg_select     = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom_range(5, 7))
                                                    : SEL_W'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (r < 65)      it.command = CMD_TICK;
    else if (r < 80) it.command = CMD_READ;
    else if (r < 97) it.command = CMD_WRITE;
    else             it.command = CMD_SPARE;
    if (it.command == CMD_WRITE && it.reg_select == SEL_CONTROL && $urandom_range(0, 9) != 0)
      it.write_data[CTL_RESET_IDX] = 1'b0;
    return it;
  endfunction

  task automatic pick_phase_config(int p, output logic [DATA_W-1:0] rr, output logic al,
                                   output logic [DATA_W-1:0] st, output logic [DATA_W-1:0] sy);
    int r;
    case (p)
      0: begin rr = 16'hffff; al = 1'b1; st = 16'd1; sy = 16'd1; end
      1: begin rr = 16'h0000; al = 1'b1; st = 16'd0; sy = 16'd0; end
      2: begin rr = 16'h007f; al = 1'b1; st = 16'hffff; sy = 16'd3; end
      3: begin rr = 16'hffff; al = 1'b1; st = 16'd2; sy = 16'hffff; end
      4: begin rr = 16'($urandom_range(0, 16'hffff)); al = 1'b0; st = 16'd1; sy = 16'd2; end
      5: begin rr = REMOTE_RATE_RST; al = 1'b1; st = STEP_TICKS_RST; sy = SYNC_TICKS_RST; end
      default: begin
        r = $urandom_range(0, 99);
        if (r < 25)      rr = 16'hffff;
        else if (r < 40) rr = 16'($urandom_range(0, 16'h007f));
        else             rr = 16'($urandom_range(0, 16'hffff));
        al = ($urandom_range(0, 99) < 85);
        st = 16'($urandom_range(0, 4));
        sy = 16'($urandom_range(0, 6));
      end
    endcase
  endtask

  task automatic send_item(item_t it, bit has_want, result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= it.command;
    in_ch.reg_select     <= it.reg_select;
    in_ch.write_data     <= it.write_data;
    in_ch.byte_mask      <= it.byte_mask;
    in_ch.fibre_present  <= it.fibre_present;
    in_ch.module_present <= it.module_present;
    cur_has_want         <= has_want;
    cur_want             <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic note_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    item_t   it;
    result_t pred;
    result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) link_config(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        it   = make_item(in_ch.command, in_ch.reg_select, in_ch.write_data, in_ch.byte_mask,
                         in_ch.fibre_present, in_ch.module_present);
        pred = link_step(it);
        pending_results.push_back(cur_has_want ? cur_want : pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, out_ch.read_data);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_ch.read_data);
          if (out_ch.link_state !== want.link_state)
            note_mismatch("link_state", 16'(want.link_state), 16'(out_ch.link_state));
          if (out_ch.current_rate !== want.current_rate)
            note_mismatch("current_rate", want.current_rate, out_ch.current_rate);
        end
      end
    end
  end

  initial begin : result_sink
    int hi;
    int lo;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      hi = gapless ? 50 : $urandom_range(1, 20);
      out_ch.ready <= 1'b1;
      repeat (hi) @(negedge clk);
      if (!gapless) begin
        lo = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (lo) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    item_t             it;
    result_t           none;
    logic [DATA_W-1:0] rr;
    logic              al;
    logic [DATA_W-1:0] st;
    logic [DATA_W-1:0] sy;
    logic [DATA_W-1:0] pref;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_READ;
    in_ch.reg_select     = SEL_CONTROL;
    in_ch.write_data     = '0;
    in_ch.byte_mask      = '0;
    in_ch.fibre_present  = 1'b0;
    in_ch.module_present = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_REMOTE_RATE;
    cfg_ch.data          = '0;
    cur_has_want         = 1'b0;
    cur_want             = '0;
    gapless              = 1'b0;
    mismatch_cnt         = 0;
    none                 = '0;
    link_reset();

    known_row(CMD_READ,  SEL_CONTROL, 16'h0000, 16'hffff, 16'h0003, PH_RESET, 16'h0000);
    known_row(CMD_READ,  SEL_STATUS,  16'h0000, 16'hffff, 16'h07f8, PH_RESET, 16'h0000);
    known_row(CMD_READ,  SEL_REMOTE,  16'h0000, 16'hffff, 16'h0007, PH_RESET, 16'h0000);
    known_row(CMD_READ,  SEL_SPARE,   16'hffff, 16'hffff, 16'h0000, PH_RESET, 16'h0000);
    known_row(CMD_SPARE, SEL_CONTROL, 16'hffff, 16'hffff, 16'h0000, PH_RESET, 16'h0000);
    known_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 16'h0000, PH_RESET, 16'h0000);
    known_row(CMD_WRITE, SEL_CONTROL, 16'h0000, 16'hffff, 16'h0002, PH_RESET, 16'h0000);
    known_row(CMD_WRITE, SEL_CURRENT, 16'hffff, 16'hffff, 16'hffff, PH_RESET, 16'h0000);
    known_row(CMD_WRITE, SEL_PREF,    16'h0000, 16'hffff, 16'h0000, PH_RESET, 16'h0000);
    known_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 16'h0000, PH_SYNC,  16'h0000);
    plain_row(CMD_WRITE, SEL_PREF,    16'hffff, 16'h0040, 1'b1, 1'b1);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b0, 1'b1);
    cfg_row(CFG_SYNC_TICKS, 16'd0);
    cfg_row(CFG_STEP_TICKS, 16'd1);
    repeat (4) plain_row(CMD_TICK, SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);
    plain_row(CMD_READ,  SEL_STATUS,  16'h0000, 16'hffff, 1'b1, 1'b1);
    plain_row(CMD_READ,  SEL_REMOTE,  16'h0000, 16'hffff, 1'b1, 1'b1);
    cfg_row(CFG_REMOTE_RATE, 16'h0000);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b0);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);
    cfg_row(CFG_REMOTE_RATE, 16'hffff);
    plain_row(CMD_WRITE, SEL_PREF,    16'hff80, 16'hffff, 1'b1, 1'b1);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);
    cfg_row(CFG_SYNC_ALLOWED, 16'd0);
    plain_row(CMD_WRITE, SEL_PREF,    16'h0001, 16'hffff, 1'b1, 1'b1);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);
    cfg_row(CFG_SYNC_ALLOWED, 16'd1);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);
    plain_row(CMD_WRITE, SEL_CONTROL, 16'hffff, 16'hffff, 1'b1, 1'b1);
    plain_row(CMD_TICK,  SEL_CONTROL, 16'h0000, 16'h0000, 1'b1, 1'b1);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        cfg_write(script[i].idx, script[i].val);
        cfg_ch.valid <= 1'b0;
      end else begin
        send_item(script[i].it, script[i].has_want, script[i].want);
      end
    end

    for (int p = 0; p < int'(PHASES); p++) begin
      drain();
      gapless = (p % 4 == 3);
      pick_phase_config(p, rr, al, st, sy);
      cfg_write(CFG_REMOTE_RATE, rr);
      cfg_write(CFG_SYNC_ALLOWED, {{(DATA_W-1){1'b0}}, al});
      cfg_write(CFG_STEP_TICKS, st);
      cfg_write(CFG_SYNC_TICKS, sy);
      cfg_ch.valid <= 1'b0;
      // release the block reset and load a preferred rate, usually a usable one
      it = make_item(CMD_WRITE, SEL_CONTROL, 16'h0000, 16'hffff, 1'b1, 1'b1);
      send_item(it, 1'b0, none);
      pref = 16'($urandom_range(0, 16'hffff));
      if ($urandom_range(0, 4) != 0) pref = pref | (16'd1 << $urandom_range(0, TOP_RATE_BIT));
      it = make_item(CMD_WRITE, SEL_PREF, pref, 16'hffff, 1'b1, 1'b1);
      send_item(it, 1'b0, none);
      for (int n = 2; n < int'(PHASE_ITEMS); n++) begin
        it = random_item();
        send_item(it, 1'b0, none);
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[fibre_link_startup_regs.f]
+incdir+rtl
rtl/flsr_pkg.sv
rtl/flsr_item_if.sv
rtl/flsr_result_if.sv
rtl/flsr_cfg_if.sv
rtl/flsr_rate_pick.sv
rtl/flsr_link_core.sv
rtl/fibre_link_startup_regs.sv
rtl/flsr_checker.sv
verif/fibre_link_startup_regs_tb.sv
